// ----- hdl/dwc_pkg.sv -----
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared constants, codes and types of the depthwise int8 convolution block.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int MAX_HEIGHT = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_KERNEL = 8;

    localparam int HB = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH);
    localparam int KB = $clog2(MAX_KERNEL);

    localparam int PIX_AW    = HB + WB;
    localparam int WGT_AW    = 2 * KB;
    localparam int PIX_DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL;

    localparam int DATA_W  = 8;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = 22;
    localparam int COORD_W = 10;
    localparam int SPAN_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IW  = 3;

    localparam int HDIM_W = 7;
    localparam int KDIM_W = 4;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_WEIGHT  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [CFG_W-1:0] PAD_UNIFORM_MAX = 32'h0000_00FF;

    typedef enum logic [CFG_IW-1:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_KERNEL_HEIGHT = 3'd2,
        REG_KERNEL_WIDTH  = 3'd3,
        REG_STRIDE        = 3'd4,
        REG_PADDING_WORD  = 3'd5,
        REG_PAD_VALUE     = 3'd6,
        REG_RELU_ENABLE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic clear;
        logic tap;
        logic in_plane;
    } mac_ctrl_t;

endpackage

// ----- hdl/dwc_mac.sv -----
// ----------------------------------------------------------------------------
// dwc_mac
// Multiply-accumulate datapath: pad select, registered product, accumulator.
// ----------------------------------------------------------------------------
module dwc_mac
    import dwc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] pixel,
    input  logic signed [DATA_W-1:0] weight,
    input  logic signed [DATA_W-1:0] pad_value,
    output logic signed [SUM_W-1:0]  acc
);

    logic signed [DATA_W-1:0] px;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  prod_ext;

    assign px       = ctrl.in_plane ? pixel : pad_value;
    assign prod_ext = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc      = acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.tap)
        begin
            prod_reg <= px * weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.tap;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

endmodule

// ----- hdl/depthwise_conv2d_int8.sv -----
// ----------------------------------------------------------------------------
// depthwise_conv2d_int8
// Depthwise 2-D convolution over one int8 plane held in on-chip memories.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall, fields req_type, row, col, value):
//   write pixel, write weight, or compute one output position.
// Output channel (out_valid / out_stall, fields out_row, out_col, sum):
//   one word per compute request, in request order; writes give no word.
// Configuration: cfg_we, cfg_index, cfg_data; written while the block is idle.
// Pixel and weight writes leave the block idle; the next word is accepted in
//   the following cycle.
// A compute request walks the kernel window one tap per cycle through the
//   single read port of the pixel memory, passes the product and accumulate
//   stages in states WAIT1 and WAIT2, and loads the output register in state
//   FINISH; a zero-sized kernel goes straight to FINISH. Input words are
//   stalled throughout, and the next word is taken in the cycle after the
//   output register is loaded.
// The output register holds a finished result while out_stall is high;
//   pixel and weight writes are still taken then, but a further compute
//   waits in its last step until the register is free.
// Reset clears the registers to in_height = in_width = kernel_height =
//   kernel_width = stride = 1 and the rest to 0. The memories are not
//   cleared: read only entries that were written.
// ----------------------------------------------------------------------------
module depthwise_conv2d_int8
    import dwc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IW-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [COORD_W-1:0]        row,
    input  logic [COORD_W-1:0]        col,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_col,
    output logic signed [SUM_W-1:0]   sum
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_WAIT1  = 5'b00100,
        ST_WAIT2  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [HDIM_W-1:0] in_height_reg, in_width_reg;
    logic [KDIM_W-1:0] kernel_height_reg, kernel_width_reg, stride_reg;
    logic [CFG_W-1:0]  padding_word_reg;
    logic signed [DATA_W-1:0] pad_value_reg;
    logic              relu_enable_reg;

    logic [HDIM_W-1:0] h_eff, w_eff;
    logic [KB:0]       kh_eff, kw_eff;
    logic [7:0]        ptop, pleft;

    logic              in_acc, out_acc, compute_acc;
    logic              pix_we, wgt_we;
    logic              zero_kernel;

    logic signed [SPAN_W-1:0] base_h_reg, base_w_reg;
    logic signed [SPAN_W-1:0] ih, iw;
    logic [COORD_W-1:0] req_row_reg, req_col_reg;
    logic [KB-1:0]      ky_reg, kx_reg;
    logic               kx_last, ky_last, last_tap, in_plane;

    logic signed [DATA_W-1:0] pix_mem [PIX_DEPTH];
    logic signed [DATA_W-1:0] wgt_mem [WGT_DEPTH];
    logic signed [DATA_W-1:0] pix_rd_reg, wgt_rd_reg;
    logic [PIX_AW-1:0]  pix_wa, pix_ra;
    logic [WGT_AW-1:0]  wgt_wa, wgt_ra;

    logic               tap_d_reg, plane_d_reg;
    mac_ctrl_t          mac_ctrl;
    logic signed [SUM_W-1:0] acc;

    logic               out_valid_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic               out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= HDIM_W'(1);
            in_width_reg      <= HDIM_W'(1);
            kernel_height_reg <= KDIM_W'(1);
            kernel_width_reg  <= KDIM_W'(1);
            stride_reg        <= KDIM_W'(1);
            padding_word_reg  <= '0;
            pad_value_reg     <= '0;
            relu_enable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IN_HEIGHT:     in_height_reg     <= cfg_data[HDIM_W-1:0];
                REG_IN_WIDTH:      in_width_reg      <= cfg_data[HDIM_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[KDIM_W-1:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[KDIM_W-1:0];
                REG_STRIDE:        stride_reg        <= cfg_data[KDIM_W-1:0];
                REG_PADDING_WORD:  padding_word_reg  <= cfg_data;
                REG_PAD_VALUE:     pad_value_reg     <= $signed(cfg_data[DATA_W-1:0]);
                REG_RELU_ENABLE:   relu_enable_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // effective sizes
    assign h_eff = (in_height_reg > HDIM_W'(MAX_HEIGHT)) ? HDIM_W'(MAX_HEIGHT)
                                                         : in_height_reg;
    assign w_eff = (in_width_reg > HDIM_W'(MAX_WIDTH)) ? HDIM_W'(MAX_WIDTH)
                                                       : in_width_reg;
    assign kh_eff = (kernel_height_reg > KDIM_W'(MAX_KERNEL)) ? (KB+1)'(MAX_KERNEL)
                                                              : (KB+1)'(kernel_height_reg);
    assign kw_eff = (kernel_width_reg > KDIM_W'(MAX_KERNEL)) ? (KB+1)'(MAX_KERNEL)
                                                             : (KB+1)'(kernel_width_reg);
    assign zero_kernel = (kh_eff == '0) || (kw_eff == '0);

    // small values pad all sides alike, larger ones carry a byte per side
    assign ptop  = padding_word_reg[7:0];
    assign pleft = (padding_word_reg <= PAD_UNIFORM_MAX) ? padding_word_reg[7:0]
                                                         : padding_word_reg[15:8];

    // handshakes and request decode
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    always_comb
    begin
        pix_we      = 1'b0;
        wgt_we      = 1'b0;
        compute_acc = 1'b0;
        if (in_acc)
        begin
            unique case (req_type)
                REQ_PIXEL:
                    pix_we = ({1'b0, row} < (COORD_W+1)'(MAX_HEIGHT)) &&
                             ({1'b0, col} < (COORD_W+1)'(MAX_WIDTH));
                REQ_WEIGHT:
                    wgt_we = ({1'b0, row} < (COORD_W+1)'(MAX_KERNEL)) &&
                             ({1'b0, col} < (COORD_W+1)'(MAX_KERNEL));
                REQ_COMPUTE:
                    compute_acc = 1'b1;
                default:
                    ;
            endcase
        end
    end

    // window walk
    assign ih = base_h_reg + $signed({{(SPAN_W-KB){1'b0}}, ky_reg});
    assign iw = base_w_reg + $signed({{(SPAN_W-KB){1'b0}}, kx_reg});
    assign in_plane = !ih[SPAN_W-1] && !iw[SPAN_W-1] &&
                      (ih[SPAN_W-2:0] < (SPAN_W-1)'(h_eff)) &&
                      (iw[SPAN_W-2:0] < (SPAN_W-1)'(w_eff));

    assign kx_last  = ({1'b0, kx_reg} == (kw_eff - (KB+1)'(1)));
    assign ky_last  = ({1'b0, ky_reg} == (kh_eff - (KB+1)'(1)));
    assign last_tap = kx_last && ky_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (compute_acc)
                begin
                    state_next = zero_kernel ? ST_FINISH : ST_RUN;
                end
            ST_RUN:
                if (last_tap)
                begin
                    state_next = ST_WAIT1;
                end
            ST_WAIT1:
                state_next = ST_WAIT2;
            ST_WAIT2:
                state_next = ST_FINISH;
            ST_FINISH:
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ky_reg      <= '0;
            kx_reg      <= '0;
            tap_d_reg   <= 1'b0;
            plane_d_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_d_reg   <= (state_reg == ST_RUN);
            plane_d_reg <= in_plane;
            if (compute_acc)
            begin
                ky_reg <= '0;
                kx_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (kx_last)
                begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + KB'(1);
                end
                else
                begin
                    kx_reg <= kx_reg + KB'(1);
                end
            end
        end
    end

    // window origin and echoed position
    always_ff @(posedge clk)
    begin
        if (compute_acc)
        begin
            base_h_reg  <= $signed(SPAN_W'(row) * SPAN_W'(stride_reg) - SPAN_W'(ptop));
            base_w_reg  <= $signed(SPAN_W'(col) * SPAN_W'(stride_reg) - SPAN_W'(pleft));
            req_row_reg <= row;
            req_col_reg <= col;
        end
    end

    // pixel and weight memories
    assign pix_wa = {row[HB-1:0], col[WB-1:0]};
    assign wgt_wa = {row[KB-1:0], col[KB-1:0]};
    assign pix_ra = {ih[HB-1:0], iw[WB-1:0]};
    assign wgt_ra = {ky_reg, kx_reg};

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_wa] <= value;
        end
        pix_rd_reg <= pix_mem[pix_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_wa] <= value;
        end
        wgt_rd_reg <= wgt_mem[wgt_ra];
    end

    assign mac_ctrl.clear    = compute_acc;
    assign mac_ctrl.tap      = tap_d_reg;
    assign mac_ctrl.in_plane = plane_d_reg;

    dwc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .pixel     (pix_rd_reg),
        .weight    (wgt_rd_reg),
        .pad_value (pad_value_reg),
        .acc       (acc)
    );

    // output register
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign sum_next = (relu_enable_reg && acc[SUM_W-1]) ? '0 : acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg <= req_row_reg;
            out_col_reg <= req_col_reg;
            sum_reg     <= sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign sum       = sum_reg;

    a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_tap) |=> (state_reg == ST_WAIT1))
        else $error("window walk did not end after the last tap");

    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && out_stall) |=>
        (state_reg == ST_FINISH))
        else $error("result left while output register was occupied");

    a_tap_source: assert property (@(posedge clk) disable iff (!rst_n)
        tap_d_reg |-> $past(state_reg == ST_RUN))
        else $error("tap reached the multiplier outside the window walk");

    a_relu: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && relu_enable_reg) |-> !sum_reg[SUM_W-1])
        else $error("negative sum with relu enabled");

endmodule

// ----- tb/sv/tb_depthwise_conv2d_int8.sv -----
// ----------------------------------------------------------------------------
// tb_depthwise_conv2d_int8
// Self-checking bench for the depthwise int8 convolution block. The kernel
// memory and one corner of the pixel memory are filled first. Directed and
// random pixel writes, weight writes and compute requests then run over a
// series of register settings; a compute request is only sent where every
// tap it reads has been written. A scoreboard predicts each window sum and
// checks every output word in order. Random input gaps and random output
// back-pressure apply except during the fill and in every fourth phase.
// ----------------------------------------------------------------------------
module tb_depthwise_conv2d_int8;
    import dwc_pkg::*;

    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int REPORT_MAX      = 10;
    localparam int FILL_ROWS       = 16;
    localparam int FILL_COLS       = 16;
    localparam int PICK_TRIES      = 16;

    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [SUM_W-1:0]   s;
    } conv_out_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IW-1:0]         cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                req_type;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [DATA_W-1:0]  value;
    logic                      out_valid;
    logic                      out_stall;
    logic [COORD_W-1:0]        out_row;
    logic [COORD_W-1:0]        out_col;
    logic signed [SUM_W-1:0]   sum;

    bit idling;
    int cycles;

    depthwise_conv2d_int8 u_top (.*);

    class conv_checker;
        logic signed [DATA_W-1:0] pixels [PIX_DEPTH];
        logic signed [DATA_W-1:0] weights [WGT_DEPTH];
        bit                       pix_known [PIX_DEPTH];
        bit                       wgt_known [WGT_DEPTH];
        logic [HDIM_W-1:0]        height;
        logic [HDIM_W-1:0]        width;
        logic [KDIM_W-1:0]        k_rows;
        logic [KDIM_W-1:0]        k_cols;
        logic [KDIM_W-1:0]        step;
        logic [CFG_W-1:0]         pad_word;
        logic signed [DATA_W-1:0] pad_val;
        logic                     relu;
        conv_out_t                sums_due[$];
        int                       fails;

        function new();
            height   = 1;
            width    = 1;
            k_rows   = 1;
            k_cols   = 1;
            step     = 1;
            pad_word = '0;
            pad_val  = '0;
            relu     = 1'b0;
            fails    = 0;
            foreach (pixels[i]) pixels[i] = '0;
            foreach (weights[i]) weights[i] = '0;
            foreach (pix_known[i]) pix_known[i] = 1'b0;
            foreach (wgt_known[i]) wgt_known[i] = 1'b0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_IN_HEIGHT:     height   = data[HDIM_W-1:0];
                REG_IN_WIDTH:      width    = data[HDIM_W-1:0];
                REG_KERNEL_HEIGHT: k_rows   = data[KDIM_W-1:0];
                REG_KERNEL_WIDTH:  k_cols   = data[KDIM_W-1:0];
                REG_STRIDE:        step     = data[KDIM_W-1:0];
                REG_PADDING_WORD:  pad_word = data;
                REG_PAD_VALUE:     pad_val  = data[DATA_W-1:0];
                REG_RELU_ENABLE:   relu     = data[0];
                default: ;
            endcase
        endfunction

        function void geometry(output int h, output int w, output int kh,
                               output int kw, output int ptop, output int pleft);
            h  = (height > MAX_HEIGHT) ? MAX_HEIGHT : int'(height);
            w  = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
            kh = (k_rows > MAX_KERNEL) ? MAX_KERNEL : int'(k_rows);
            kw = (k_cols > MAX_KERNEL) ? MAX_KERNEL : int'(k_cols);
            // small words pad all sides alike, larger ones carry a byte per side
            if (pad_word <= PAD_UNIFORM_MAX) begin
                ptop  = int'(pad_word);
                pleft = int'(pad_word);
            end
            else begin
                ptop  = int'(pad_word[7:0]);
                pleft = int'(pad_word[15:8]);
            end
        endfunction

        // true when every tap of the window reads a written entry
        function bit window_known(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
            int h, w, kh, kw, ptop, pleft, ky, kx, ih, iw;
            geometry(h, w, kh, kw, ptop, pleft);
            for (ky = 0; ky < kh; ky++) begin
                for (kx = 0; kx < kw; kx++) begin
                    if (!wgt_known[ky * MAX_KERNEL + kx])
                        return 1'b0;
                    ih = int'(r) * int'(step) - ptop + ky;
                    iw = int'(c) * int'(step) - pleft + kx;
                    if (ih >= 0 && ih < h && iw >= 0 && iw < w &&
                        !pix_known[ih * MAX_WIDTH + iw])
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function int window_sum(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
            int h, w, kh, kw, ptop, pleft, ky, kx, ih, iw, px, wt, acc;
            geometry(h, w, kh, kw, ptop, pleft);
            acc = 0;
            for (ky = 0; ky < kh; ky++) begin
                for (kx = 0; kx < kw; kx++) begin
                    ih = int'(r) * int'(step) - ptop + ky;
                    iw = int'(c) * int'(step) - pleft + kx;
                    px = int'(pad_val);
                    if (ih >= 0 && ih < h && iw >= 0 && iw < w)
                        px = int'(pixels[ih * MAX_WIDTH + iw]);
                    wt = int'(weights[ky * MAX_KERNEL + kx]);
                    acc += px * wt;
                end
            end
            if (relu && acc < 0)
                acc = 0;
            return acc;
        endfunction

        function void note_word(logic [1:0] kind, logic [COORD_W-1:0] r,
                                logic [COORD_W-1:0] c, logic signed [DATA_W-1:0] v);
            conv_out_t e;
            int        acc;
            case (kind)
                REQ_PIXEL:
                    if (r < MAX_HEIGHT && c < MAX_WIDTH) begin
                        pixels[r * MAX_WIDTH + c]    = v;
                        pix_known[r * MAX_WIDTH + c] = 1'b1;
                    end
                REQ_WEIGHT:
                    if (r < MAX_KERNEL && c < MAX_KERNEL) begin
                        weights[r * MAX_KERNEL + c]   = v;
                        wgt_known[r * MAX_KERNEL + c] = 1'b1;
                    end
                REQ_COMPUTE:
                begin
                    acc = window_sum(r, c);
                    e.r = r;
                    e.c = c;
                    e.s = acc[SUM_W-1:0];
                    sums_due.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                 logic [SUM_W-1:0] s);
            conv_out_t e;
            if (sums_due.size() == 0) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("unexpected output word: row %0d col %0d sum %0d",
                             r, c, $signed(s));
                return;
            end
            e = sums_due.pop_front();
            if (r !== e.r || c !== e.c || s !== e.s) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display({"mismatch: expected row %0d col %0d sum %0d, ",
                              "got row %0d col %0d sum %0d"},
                             e.r, e.c, $signed(e.s), r, c, $signed(s));
            end
        endfunction
    endclass

    conv_checker book = new();

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        if (!idling)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80)
            return $urandom_range(1, 16);
        if (p < 88)
            return MAX_HEIGHT;
        if (p < 95)
            return $urandom_range(17, 127);
        return 0;
    endfunction

    function automatic logic [CFG_W-1:0] pick_kdim();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 8);
        return $urandom_range(0, 15);
    endfunction

    task automatic put_word(logic [1:0] kind, logic [COORD_W-1:0] r,
                            logic [COORD_W-1:0] c, logic [DATA_W-1:0] v);
        int gap;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        row      <= r;
        col      <= c;
        value    <= v;
        do @(posedge clk); while (in_stall);
        book.note_word(kind, r, c, v);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.write_reg(idx, data);
    endtask

    // wait until every output word is back, then let the block go quiet
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.sums_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_phase(int ph);
        logic [CFG_W-1:0] cfg [8];
        int               i;
        int               p;
        case (ph)
            0:
            begin
                cfg[REG_IN_HEIGHT] = 8;   cfg[REG_IN_WIDTH] = 8;
                cfg[REG_KERNEL_HEIGHT] = 3; cfg[REG_KERNEL_WIDTH] = 3;
                cfg[REG_STRIDE] = 1;      cfg[REG_PADDING_WORD] = 1;
                cfg[REG_PAD_VALUE] = 8'h80; cfg[REG_RELU_ENABLE] = 0;
            end
            1:
            begin
                cfg[REG_IN_HEIGHT] = 64;  cfg[REG_IN_WIDTH] = 64;
                cfg[REG_KERNEL_HEIGHT] = 8; cfg[REG_KERNEL_WIDTH] = 8;
                cfg[REG_STRIDE] = 1;      cfg[REG_PADDING_WORD] = 0;
                cfg[REG_PAD_VALUE] = 8'h7F; cfg[REG_RELU_ENABLE] = 1;
            end
            2:
            begin
                // empty plane, oversized kernel, stride zero: all taps are pad
                cfg[REG_IN_HEIGHT] = 0;   cfg[REG_IN_WIDTH] = 127;
                cfg[REG_KERNEL_HEIGHT] = 15; cfg[REG_KERNEL_WIDTH] = 8;
                cfg[REG_STRIDE] = 0;      cfg[REG_PADDING_WORD] = 32'hFFFF_FFFF;
                cfg[REG_PAD_VALUE] = 8'h7F; cfg[REG_RELU_ENABLE] = 1;
            end
            3:
            begin
                cfg[REG_IN_HEIGHT] = 1;   cfg[REG_IN_WIDTH] = 1;
                cfg[REG_KERNEL_HEIGHT] = 1; cfg[REG_KERNEL_WIDTH] = 0;
                cfg[REG_STRIDE] = 15;     cfg[REG_PADDING_WORD] = PAD_UNIFORM_MAX;
                cfg[REG_PAD_VALUE] = 8'h80; cfg[REG_RELU_ENABLE] = 0;
            end
            4:
            begin
                cfg[REG_IN_HEIGHT] = 12;  cfg[REG_IN_WIDTH] = 20;
                cfg[REG_KERNEL_HEIGHT] = 5; cfg[REG_KERNEL_WIDTH] = 2;
                cfg[REG_STRIDE] = 2;      cfg[REG_PADDING_WORD] = 32'h0302_0103;
                cfg[REG_PAD_VALUE] = $urandom_range(0, 255);
                cfg[REG_RELU_ENABLE] = 1;
            end
            5:
            begin
                cfg[REG_IN_HEIGHT] = 127; cfg[REG_IN_WIDTH] = 127;
                cfg[REG_KERNEL_HEIGHT] = 8; cfg[REG_KERNEL_WIDTH] = 8;
                cfg[REG_STRIDE] = 8;      cfg[REG_PADDING_WORD] = 32'h0000_0100;
                cfg[REG_PAD_VALUE] = 0;   cfg[REG_RELU_ENABLE] = 0;
            end
            default:
            begin
                cfg[REG_IN_HEIGHT]     = pick_dim();
                cfg[REG_IN_WIDTH]      = pick_dim();
                cfg[REG_KERNEL_HEIGHT] = pick_kdim();
                cfg[REG_KERNEL_WIDTH]  = pick_kdim();
                cfg[REG_STRIDE] = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3)
                                                              : $urandom_range(0, 15);
                p = $urandom_range(0, 99);
                if (p < 45)
                    cfg[REG_PADDING_WORD] = $urandom_range(0, 3);
                else if (p < 55)
                    cfg[REG_PADDING_WORD] = $urandom_range(0, 255);
                else begin
                    cfg[REG_PADDING_WORD] = {8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 4)),
                                             8'($urandom_range(0, 4))};
                    if (cfg[REG_PADDING_WORD] <= PAD_UNIFORM_MAX)
                        cfg[REG_PADDING_WORD][8] = 1'b1;
                end
                cfg[REG_PAD_VALUE]   = $urandom_range(0, 255);
                cfg[REG_RELU_ENABLE] = $urandom_range(0, 1);
            end
        endcase
        for (i = 0; i < 8; i++)
            set_reg(cfg_idx_t'(i), cfg[i]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_mix(int n);
        int               i;
        int               p;
        int               span;
        int               t;
        int               lim;
        bit               found;
        logic [COORD_W-1:0] r, c;
        for (i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 45) begin
                // mostly positions whose window touches the plane
                span = (int'(book.height) + 4) / ((book.step == 0) ? 1 : int'(book.step));
                found = 1'b0;
                r = '0;
                c = '0;
                for (t = 0; t < PICK_TRIES && !found; t++) begin
                    // later tries stay near the origin, where the plane is filled
                    lim = (t < PICK_TRIES / 2) ? span : 3;
                    if ($urandom_range(0, 99) < 85) begin
                        r = COORD_W'($urandom_range(0, lim));
                        c = COORD_W'($urandom_range(0, lim));
                    end
                    else begin
                        r = COORD_W'($urandom_range(0, 1023));
                        c = COORD_W'($urandom_range(0, 1023));
                    end
                    found = book.window_known(r, c);
                end
                if (found)
                    put_word(REQ_COMPUTE, r, c, DATA_W'($urandom_range(0, 255)));
                else
                    put_word(REQ_PIXEL, COORD_W'($urandom_range(0, MAX_HEIGHT - 1)),
                             COORD_W'($urandom_range(0, MAX_WIDTH - 1)),
                             DATA_W'($urandom_range(0, 255)));
            end
            else if (p < 75) begin
                if ($urandom_range(0, 99) < 85)
                    put_word(REQ_PIXEL, COORD_W'($urandom_range(0, MAX_HEIGHT - 1)),
                             COORD_W'($urandom_range(0, MAX_WIDTH - 1)),
                             DATA_W'($urandom_range(0, 255)));
                else
                    put_word(REQ_PIXEL, COORD_W'($urandom_range(0, 1023)),
                             COORD_W'($urandom_range(0, 1023)),
                             DATA_W'($urandom_range(0, 255)));
            end
            else if (p < 93) begin
                if ($urandom_range(0, 99) < 85)
                    put_word(REQ_WEIGHT, COORD_W'($urandom_range(0, MAX_KERNEL - 1)),
                             COORD_W'($urandom_range(0, MAX_KERNEL - 1)),
                             DATA_W'($urandom_range(0, 255)));
                else
                    put_word(REQ_WEIGHT, COORD_W'($urandom_range(0, 1023)),
                             COORD_W'($urandom_range(0, 1023)),
                             DATA_W'($urandom_range(0, 255)));
            end
            else
                put_word(REQ_NONE, COORD_W'($urandom_range(0, 1023)),
                         COORD_W'($urandom_range(0, 1023)),
                         DATA_W'($urandom_range(0, 255)));
        end
    endtask

    // output back-pressure
    initial
    begin
        int   hold;
        logic stall_now;
        out_stall = 1'b0;
        hold      = 0;
        forever begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else begin
                stall_now = idling && ($urandom_range(0, 3) == 0);
                hold      = stall_now ? gap_len() : $urandom_range(0, 6);
                out_stall <= stall_now;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
            book.check_word(out_row, out_col, sum);
    end

    initial
    begin
        int ph;
        int i;
        int j;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        req_type  = REQ_PIXEL;
        row       = '0;
        col       = '0;
        value     = '0;
        idling    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the kernel memory and one corner of the pixel memory
        for (i = 0; i < FILL_ROWS; i++)
            for (j = 0; j < FILL_COLS; j++)
                put_word(REQ_PIXEL, COORD_W'(i), COORD_W'(j),
                         DATA_W'($urandom_range(0, 255)));
        for (i = 0; i < MAX_KERNEL; i++)
            for (j = 0; j < MAX_KERNEL; j++)
                put_word(REQ_WEIGHT, COORD_W'(i), COORD_W'(j),
                         DATA_W'($urandom_range(0, 255)));

        // directed words under the reset settings
        idling = 1'b1;
        put_word(REQ_PIXEL, '0, '0, 8'h80);
        put_word(REQ_WEIGHT, '0, '0, 8'h7F);
        put_word(REQ_COMPUTE, '0, '0, 8'h00);
        put_word(REQ_WEIGHT, '0, '0, 8'h80);
        put_word(REQ_COMPUTE, '0, '0, 8'hFF);
        put_word(REQ_PIXEL, COORD_W'(MAX_HEIGHT - 1), COORD_W'(MAX_WIDTH - 1), 8'h7F);
        put_word(REQ_WEIGHT, COORD_W'(MAX_KERNEL - 1), COORD_W'(MAX_KERNEL - 1), 8'h80);
        // out-of-range writes are dropped
        put_word(REQ_PIXEL, COORD_W'(MAX_HEIGHT), '0, 8'h01);
        put_word(REQ_PIXEL, '0, COORD_W'(MAX_WIDTH), 8'h02);
        put_word(REQ_PIXEL, COORD_W'(1023), COORD_W'(1023), 8'hFF);
        put_word(REQ_WEIGHT, COORD_W'(MAX_KERNEL), '0, 8'h03);
        put_word(REQ_WEIGHT, '0, COORD_W'(MAX_KERNEL), 8'h04);
        put_word(REQ_WEIGHT, COORD_W'(1023), COORD_W'(1023), 8'hFF);
        put_word(REQ_NONE, COORD_W'(1023), COORD_W'(1023), 8'hFF);
        put_word(REQ_NONE, '0, '0, 8'h00);
        put_word(REQ_COMPUTE, '0, '0, 8'h7F);
        put_word(REQ_COMPUTE, COORD_W'(1023), COORD_W'(1023), 8'h00);
        put_word(REQ_COMPUTE, '0, COORD_W'(1023), 8'h00);
        put_word(REQ_COMPUTE, COORD_W'(1023), '0, 8'h00);
        put_word(REQ_COMPUTE, COORD_W'(1), '0, 8'h00);
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            program_phase(ph);
            // every fourth phase runs back to back
            idling = (ph % 4 != 3);
            run_mix(ITEMS_PER_PHASE);
            drain();
        end

        if (book.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dwc_pkg.sv
hdl/dwc_mac.sv
hdl/depthwise_conv2d_int8.sv
tb/sv/tb_depthwise_conv2d_int8.sv
